@@ src/priority_slice_job_scheduler_top_defines.svh @@
// Assertion helpers shared by the scheduler RTL.
// Each macro expects signals named clk and arst_n in the calling scope.
`ifndef PRIORITY_SLICE_JOB_SCHEDULER_TOP_DEFINES_SVH
`define PRIORITY_SLICE_JOB_SCHEDULER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PSS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define PSS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/pss_pkg.sv @@
package pss_pkg;

	// Default table depth and fixed field widths.
	localparam int DEPTH_DEF = 64;
	localparam int PRI_W     = 10;
	localparam int TIME_W    = 16;
	localparam int SLICE_W   = 8;
	localparam int SLOT_W    = 6;
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;

	// Jobs at or above this priority are never selected.
	localparam logic [PRI_W-1:0]   PRI_LIMIT   = 10'd1000;
	localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd1;

	// Register index decoded from the word address bit.
	localparam logic REG_SLICE_IDX = 1'b0;

	typedef enum logic {
		OP_LOAD     = 1'b0,
		OP_DISPATCH = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_FLUSH,
		S_PICK,
		S_LOAD
	} state_t;

	// One table entry as stored in the job memory.
	typedef struct packed {
		logic [PRI_W-1:0]  pri;
		logic [TIME_W-1:0] arr;
		logic [TIME_W-1:0] rem;
		logic              started;
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic scan_step;
		logic pick;
		logic load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic count_zero;
		logic scan_last;
		logic out_free;
	} sts_t;

endpackage

@@ src/pss_ctrl.sv @@
module pss_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          op,
	input  pss_pkg::sts_t sts,
	output pss_pkg::cmd_t cmd
);
	import pss_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					if (op == OP_LOAD) begin
						state_d = S_LOAD;
					end else if (sts.count_zero) begin
						state_d = S_PICK;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				state_d = S_PICK;
			end
			S_PICK: begin
				if (sts.out_free) begin
					cmd.pick = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_LOAD: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ src/pss_dp.sv @@
module pss_dp #(
	parameter int TABLE_DEPTH = pss_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pss_pkg::cmd_t                 cmd,
	output pss_pkg::sts_t                 sts,
	input  logic [pss_pkg::PRI_W-1:0]     job_priority,
	input  logic [pss_pkg::TIME_W-1:0]    job_arrival,
	input  logic [pss_pkg::TIME_W-1:0]    job_run_time,
	input  logic [pss_pkg::SLICE_W-1:0]   slice_length,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pss_pkg::SLOT_W-1:0]    slot,
	output logic                          table_full,
	output logic                          none_left,
	output logic                          first_run,
	output logic                          finished,
	output logic [pss_pkg::TIME_W-1:0]    time_left
);
	import pss_pkg::*;

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	entry_t mem [TABLE_DEPTH];

	logic [CW-1:0]     job_count_q;
	logic [IW-1:0]     cnt_q;
	entry_t            rd_s1;
	logic [IW-1:0]     rd_idx_s1;
	logic              rd_vld_s1;
	entry_t            best_q;
	logic [IW-1:0]     best_idx_q;
	logic              found_q;
	entry_t            item_q;
	logic              out_valid_q;
	logic              full;
	logic              elig;
	logic              better;
	logic [TIME_W-1:0] new_rem;
	logic              mem_we;
	logic [IW-1:0]     mem_waddr;
	entry_t            mem_wdata;

	// Status toward the controller.
	assign full            = (job_count_q == CW'(TABLE_DEPTH));
	assign sts.count_zero  = (job_count_q == '0);
	assign sts.scan_last   = (cnt_q == IW'(job_count_q - CW'(1)));
	assign sts.out_free    = !out_valid_q || out_ready;

	// Candidate compare: lower priority, then earlier arrival, then less time left.
	assign elig   = (rd_s1.rem != '0) && (rd_s1.pri < PRI_LIMIT);
	assign better = !found_q || (rd_s1.pri < best_q.pri) ||
		((rd_s1.pri == best_q.pri) && ((rd_s1.arr < best_q.arr) ||
		((rd_s1.arr == best_q.arr) && (rd_s1.rem < best_q.rem))));

	// Remaining time after one slice, clamped at zero.
	assign new_rem = (best_q.rem > TIME_W'(slice_length)) ?
		(best_q.rem - TIME_W'(slice_length)) : '0;

	// Memory write: a new job on load, the updated entry on dispatch.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = best_idx_q;
		mem_wdata = '{pri: best_q.pri, arr: best_q.arr, rem: new_rem, started: 1'b1};
		if (cmd.load && !full) begin
			mem_we    = 1'b1;
			mem_waddr = IW'(job_count_q);
			mem_wdata = item_q;
		end else if (cmd.pick && found_q) begin
			mem_we = 1'b1;
		end
	end

	// Job memory with registered read for the scan.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (cmd.scan_step) begin
			rd_s1     <= mem[cnt_q];
			rd_idx_s1 <= cnt_q;
		end
	end

	// Scan control, job count and best-so-far flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_count_q <= '0;
			cnt_q       <= '0;
			rd_vld_s1   <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_step;
			if (cmd.capture) begin
				cnt_q   <= '0;
				found_q <= 1'b0;
			end else if (cmd.scan_step) begin
				cnt_q <= cnt_q + IW'(1);
			end
			if (rd_vld_s1 && elig) begin
				found_q <= 1'b1;
			end
			if (cmd.load && !full) begin
				job_count_q <= job_count_q + CW'(1);
			end
		end
	end

	// Best entry so far and the captured load item.
	always_ff @(posedge clk) begin
		if (rd_vld_s1 && elig && better) begin
			best_q     <= rd_s1;
			best_idx_q <= rd_idx_s1;
		end
		if (cmd.capture) begin
			item_q <= '{pri: job_priority, arr: job_arrival, rem: job_run_time,
				started: 1'b0};
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load || cmd.pick) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			slot       <= full ? '0 : SLOT_W'(job_count_q);
			table_full <= full;
			none_left  <= 1'b0;
			first_run  <= 1'b0;
			finished   <= 1'b0;
			time_left  <= '0;
		end else if (cmd.pick) begin
			table_full <= 1'b0;
			none_left  <= !found_q;
			slot       <= found_q ? SLOT_W'(best_idx_q) : '0;
			first_run  <= found_q && !best_q.started;
			finished   <= found_q && (new_rem == '0);
			time_left  <= found_q ? new_rem : '0;
		end
	end

	assign out_valid = out_valid_q;

`include "priority_slice_job_scheduler_top_defines.svh"

	`PSS_ASSERT_NOW(a_count_bound, 1'b1, job_count_q <= CW'(TABLE_DEPTH), "job count over depth")
	`PSS_ASSERT_NEXT(a_count_inc, cmd.load && !full, job_count_q == $past(job_count_q) + CW'(1), "load did not advance count")
	`PSS_ASSERT_NOW(a_flags_excl, out_valid_q, !(table_full && none_left), "full and none_left both set")
	`PSS_ASSERT_NOW(a_no_scan_write, cmd.scan_step, !mem_we, "memory written during scan")

endmodule

@@ src/priority_slice_job_scheduler_top.sv @@
// Priority job scheduler with time-slice dispatch.
// Input channel (in_valid/in_ready) carries one item: op selects load or dispatch;
// job_priority, job_arrival and job_run_time matter for loads only.
// Output channel (out_valid/out_ready) returns exactly one item per input item.
// A load passes from acceptance through the load state into the output register;
// a dispatch first runs a scan over the N loaded jobs that reads one table entry
// per cycle through the single job memory read port, then a flush and a pick state.
// A dispatch on an empty table skips the scan.
// One item is processed at a time; the next item is accepted as soon as the
// previous result sits in the output register, even if it is not yet taken.
// If the receiver stalls, the finished result holds in the output register and
// a following item waits at its final step until the register is free.
// The APB port holds slice_length at byte address 0 (reset value 1); write it
// only while the block is idle.
// Reset clears the job count and all control state; the table contents need no
// clearing since only entries below the job count are ever read.
module priority_slice_job_scheduler_top #(
	parameter int TABLE_DEPTH = pss_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pss_pkg::ADDR_W-1:0]    paddr,
	input  logic [pss_pkg::DATA_W-1:0]    pwdata,
	output logic [pss_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          op,
	input  logic [pss_pkg::PRI_W-1:0]     job_priority,
	input  logic [pss_pkg::TIME_W-1:0]    job_arrival,
	input  logic [pss_pkg::TIME_W-1:0]    job_run_time,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pss_pkg::SLOT_W-1:0]    slot,
	output logic                          table_full,
	output logic                          none_left,
	output logic                          first_run,
	output logic                          finished,
	output logic [pss_pkg::TIME_W-1:0]    time_left
);
	import pss_pkg::*;

	logic [SLICE_W-1:0] slice_q;
	logic               reg_hit;
	cmd_t               cmd;
	sts_t               sts;

	// Register decode on the word address bit.
	assign reg_hit = (paddr[ADDR_W-1] == REG_SLICE_IDX);
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? DATA_W'(slice_q) : '0;

	// Slice length register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_q <= SLICE_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			slice_q <= pwdata[SLICE_W-1:0];
		end
	end

	pss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (op),
		.sts      (sts),
		.cmd      (cmd)
	);

	pss_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.job_priority (job_priority),
		.job_arrival  (job_arrival),
		.job_run_time (job_run_time),
		.slice_length (slice_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.slot         (slot),
		.table_full   (table_full),
		.none_left    (none_left),
		.first_run    (first_run),
		.finished     (finished),
		.time_left    (time_left)
	);

endmodule
